>>> rtl/core/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants and types for the positional list: command codes, status
// codes, default sizes and the command that drives the row of entry cells.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int DEPTH_DEF       = 256;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_POS  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REM_HEAD = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REM_TAIL = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REM_POS  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INS_REJ = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REM_REJ = 2'd2;

	// Broadcast to every cell; at most one of the two is set in a cycle.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

>>> rtl/core/positional_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove_top
// Ordered list of up to DEPTH entries with insert and remove at head, tail or
// a given position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns one result beat for it.
// An accepted command steps through EXEC, in which the whole row of cells
// shifts at once, WAIT, while the registered OR tree gathers the removed
// entry, FINISH, which captures it, and HOLD, which loads the output register.
// The next command is taken only after that. in_stall is high while a command
// is in flight, and a result waiting on out_stall holds the block before it
// takes the next command.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_top #(
	parameter int DEPTH       = pli_pkg::DEPTH_DEF,
	parameter int ENTRY_WIDTH = pli_pkg::ENTRY_WIDTH_DEF,
	localparam int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pli_pkg::FUNC_W-1:0]     func,
	input  logic [CNT_W-1:0]               position,
	input  logic [ENTRY_WIDTH-1:0]         entry_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ENTRY_WIDTH-1:0]         removed_value,
	output logic [pli_pkg::STATUS_W-1:0]   status,
	output logic [CNT_W-1:0]               entry_count
);

	localparam int TREE_LVLS = $clog2(DEPTH);
	localparam int WAIT_W    = $clog2(TREE_LVLS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_FINISH,
		S_HOLD
	} state_t;

	state_t                         state_q;
	logic [WAIT_W-1:0]              wait_q;
	logic [CNT_W-1:0]               count_q;
	logic [pli_pkg::FUNC_W-1:0]     func_q;
	logic [CNT_W-1:0]               pos_q;
	logic [ENTRY_WIDTH-1:0]         val_q;
	logic [pli_pkg::STATUS_W-1:0]   res_status_q;
	logic [ENTRY_WIDTH-1:0]         res_value_q;
	logic                           out_valid_q;
	logic [ENTRY_WIDTH-1:0]         removed_q;
	logic [pli_pkg::STATUS_W-1:0]   status_q;
	logic [CNT_W-1:0]               entry_count_q;

	logic                           is_ins;
	logic                           is_rem;
	logic [CNT_W-1:0]               ins_tgt;
	logic [CNT_W-1:0]               rem_tgt;
	logic                           ins_ok;
	logic                           rem_ok;
	pli_pkg::cell_cmd_t             cmd;
	logic [CNT_W-1:0]               tgt;
	logic [ENTRY_WIDTH-1:0]         tree_root;
	logic                           in_accept;
	logic                           out_free;

	logic [ENTRY_WIDTH-1:0]         cell_val [DEPTH];
	logic [ENTRY_WIDTH-1:0]         cell_rd  [DEPTH];

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		is_ins  = func_q inside {pli_pkg::FN_INS_HEAD, pli_pkg::FN_INS_TAIL, pli_pkg::FN_INS_POS};
		is_rem  = func_q inside {pli_pkg::FN_REM_HEAD, pli_pkg::FN_REM_TAIL, pli_pkg::FN_REM_POS};
		ins_tgt = pos_q;
		rem_tgt = pos_q;
		case (func_q)
			pli_pkg::FN_INS_HEAD: ins_tgt = '0;
			pli_pkg::FN_INS_TAIL: ins_tgt = count_q;
			pli_pkg::FN_REM_HEAD: rem_tgt = '0;
			pli_pkg::FN_REM_TAIL: rem_tgt = count_q - CNT_W'(1);
			default: begin
				ins_tgt = pos_q;
				rem_tgt = pos_q;
			end
		endcase
		ins_ok  = (count_q < CNT_W'(DEPTH)) && (ins_tgt <= count_q);
		rem_ok  = (count_q != '0) && (rem_tgt < count_q);
		cmd.ins = (state_q == S_EXEC) && is_ins && ins_ok;
		cmd.rem = (state_q == S_EXEC) && is_rem && rem_ok;
		tgt     = is_ins ? ins_tgt : rem_tgt;
	end

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_v;
		logic [ENTRY_WIDTH-1:0] right_v;

		if (gi == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_val[gi-1];
		end
		if (gi == DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_val[gi+1];
		end

		pli_cell #(
			.IDX         (gi),
			.ENTRY_WIDTH (ENTRY_WIDTH),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.tgt         (tgt),
			.wr_value    (val_q),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_val[gi]),
			.rd_value    (cell_rd[gi])
		);
	end

	pli_or_tree #(
		.N (DEPTH),
		.W (ENTRY_WIDTH)
	) u_tree (
		.clk  (clk),
		.leaf (cell_rd),
		.root (tree_root)
	);

	// Command capture and result staging are payload only.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= entry_value;
		end
		if (state_q == S_EXEC) begin
			if (is_ins && !ins_ok) begin
				res_status_q <= pli_pkg::ST_INS_REJ;
			end else if (is_rem && !rem_ok) begin
				res_status_q <= pli_pkg::ST_REM_REJ;
			end else begin
				res_status_q <= pli_pkg::ST_DONE;
			end
		end
		if (state_q == S_FINISH) begin
			res_value_q <= tree_root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.ins) begin
						count_q <= count_q + CNT_W'(1);
					end else if (cmd.rem) begin
						count_q <= count_q - CNT_W'(1);
					end
					wait_q  <= WAIT_W'(TREE_LVLS - 1);
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (wait_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						wait_q <= wait_q - WAIT_W'(1);
					end
				end
				S_FINISH: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						removed_q     <= res_value_q;
						status_q      <= res_status_q;
						entry_count_q <= count_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above list depth");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !cmd.ins && !cmd.rem) |=> $stable(count_q))
		else $error("count changed on a rejected or ignored command");

	a_remove_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && cmd.rem) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("successful removal did not shrink the list by one");

	a_reject_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != pli_pkg::ST_DONE) |-> (removed_q == '0))
		else $error("rejected command returned a nonzero entry");

endmodule

>>> rtl/core/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell
// One list position. Holds an entry and, on a broadcast command, takes the
// entry of its left neighbor (insert) or its right neighbor (remove), or the
// new entry when it is the insert target. Offers its entry when it is the
// removal target.
// ----------------------------------------------------------------------------
module pli_cell #(
	parameter int IDX         = 0,
	parameter int ENTRY_WIDTH = pli_pkg::ENTRY_WIDTH_DEF,
	parameter int CNT_W       = 9
) (
	input  logic                   clk,
	input  pli_pkg::cell_cmd_t     cmd,
	input  logic [CNT_W-1:0]       tgt,
	input  logic [ENTRY_WIDTH-1:0] wr_value,
	input  logic [ENTRY_WIDTH-1:0] left_value,
	input  logic [ENTRY_WIDTH-1:0] right_value,
	output logic [ENTRY_WIDTH-1:0] value,
	output logic [ENTRY_WIDTH-1:0] rd_value
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [ENTRY_WIDTH-1:0] val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX > tgt) begin
				val_q <= left_value;
			end else if (MY_IDX == tgt) begin
				val_q <= wr_value;
			end
		end else if (cmd.rem && MY_IDX >= tgt) begin
			val_q <= right_value;
		end
	end

	assign value    = val_q;
	assign rd_value = (cmd.rem && MY_IDX == tgt) ? val_q : '0;

endmodule

>>> rtl/core/pli_or_tree.sv
// ----------------------------------------------------------------------------
// pli_or_tree
// Registered binary OR tree that gathers the one nonzero cell output into a
// single word. The leaves are registered first, then each level of the tree
// in turn up to the root.
// ----------------------------------------------------------------------------
module pli_or_tree #(
	parameter int N = pli_pkg::DEPTH_DEF,
	parameter int W = pli_pkg::ENTRY_WIDTH_DEF
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);

	localparam int LVLS = $clog2(N);
	localparam int P    = 2 ** LVLS;

	// Heap order: node k combines nodes 2k and 2k+1, leaves sit at P..2P-1.
	logic [W-1:0] node_q [1:2*P-1];

	for (genvar gk = 0; gk < P; gk++) begin : g_leaf
		if (gk < N) begin : g_used
			always_ff @(posedge clk) begin
				node_q[P+gk] <= leaf[gk];
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_q[P+gk] <= '0;
			end
		end
	end

	for (genvar gn = 1; gn < P; gn++) begin : g_node
		always_ff @(posedge clk) begin
			node_q[gn] <= node_q[2*gn] | node_q[2*gn+1];
		end
	end

	assign root = node_q[1];

endmodule
